>>> rtl/core/chc_pkg.sv
`default_nettype none

package chc_pkg;

    // Default arithmetic precision of the normalized axes and the rotation count.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Angles are degrees with sixteen fraction bits; the accumulator is signed.
    localparam int ANG_FRAC = 16;
    localparam int ZW       = 27;
    localparam int TBL_IW   = 5;

    localparam logic signed [ZW-1:0] Z_90  = ZW'(90 * (1 << ANG_FRAC));
    localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * (1 << ANG_FRAC));
    localparam logic signed [ZW-1:0] Z_360 = ZW'(360 * (1 << ANG_FRAC));
    localparam logic [9:0]           DEG_TURN = 10'd360;

    // Function codes of an input item.
    localparam logic FUNC_CAL  = 1'b0;
    localparam logic FUNC_HEAD = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] x_low;
        logic [7:0] x_high;
        logic [7:0] y_low;
        logic [7:0] y_high;
    } t_in_item;

    typedef struct packed {
        logic [8:0] heading_deg;
        logic       range_error;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM_LOAD,
        ST_NORM_DIV,
        ST_NORM_END,
        ST_ROT_PRE,
        ST_ROT_STEP,
        ST_WRAP,
        ST_DONE
    } t_state;

    // Arctangent of 2^-i in degrees, sixteen fraction bits, rounded.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [TBL_IW-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/compass_heading_calibrated.sv
// Calibration item: a new item may follow in the next cycle.
// Heading item: the shared restoring divider normalizes X then Y, the CORDIC does
// one rotation per cycle and the angle is wrapped; a zero span skips to the result.
// The result is registered unless the output stalls, and the next item is taken in
// the cycle after it, so no new item is taken while a heading is in progress.
// Synchronous active-low reset returns to idle and restores the limits.
`default_nettype none

module compass_heading_calibrated
    import chc_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    localparam int QW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 3;
    localparam int CW = FRAC_BITS + 5;
    localparam int SW = $clog2(CORDIC_STEPS);
    localparam int DW = $clog2(FRAC_BITS + 2);

    t_state r_state, n_state;

    logic signed [15:0] r_x_min, n_x_min, r_x_max, n_x_max;
    logic signed [15:0] r_y_min, n_y_min, r_y_max, n_y_max;
    logic               r_out_valid, n_out_valid;

    logic signed [15:0] r_xv, n_xv, r_yv, n_yv;
    logic               r_err, n_err;
    logic               r_axis, n_axis;
    logic               r_neg, n_neg;
    logic               r_sat, n_sat;
    logic [15:0]        r_ud, n_ud;
    logic [15:0]        r_rem, n_rem;
    logic [QW-1:0]      r_dsh, n_dsh;
    logic [QW-1:0]      r_q, n_q;
    logic [DW-1:0]      r_cnt, n_cnt;
    logic signed [NW-1:0] r_nx, n_nx, r_ny, n_ny;
    logic signed [CW-1:0] r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [SW-1:0]      r_step, n_step;
    t_out_item          r_out, n_out;

    logic               in_take, span_zero, out_load;
    logic signed [15:0] cur_v, cur_lo, cur_hi;
    logic signed [17:0] num, num_neg;
    logic signed [16:0] den, den_neg;
    logic [16:0]        un;
    logic [15:0]        ud;
    logic               norm_neg, norm_sat;
    logic [16:0]        div_t, div_diff;
    logic               div_ge;
    logic signed [NW-1:0] norm_val;
    logic signed [CW-1:0] pre_x, pre_y, sh_x, sh_y;
    logic               pre_direct;
    logic [9:0]         deg_raw, deg_wrap;
    logic signed [15:0] in_xv, in_yv;

    // Raw bytes joined into signed axis readings.
    assign in_xv = {i_in_data.x_high, i_in_data.x_low};
    assign in_yv = {i_in_data.y_high, i_in_data.y_low};
    assign in_take = i_in_valid && !o_in_stall;
    assign span_zero = (r_x_max == r_x_min) || (r_y_max == r_y_min);

    // Normalizer front end: numerator, span, signs and saturation test of one axis.
    always_comb begin
        cur_v    = r_axis ? r_yv : r_xv;
        cur_lo   = r_axis ? r_y_min : r_x_min;
        cur_hi   = r_axis ? r_y_max : r_x_max;
        num      = ({{2{cur_v[15]}}, cur_v} <<< 1) - {{2{cur_lo[15]}}, cur_lo}
                   - {{2{cur_hi[15]}}, cur_hi};
        num_neg  = -num;
        den      = {cur_hi[15], cur_hi} - {cur_lo[15], cur_lo};
        den_neg  = -den;
        un       = num[17] ? num_neg[16:0] : num[16:0];
        ud       = den[16] ? den_neg[15:0] : den[15:0];
        norm_neg = num[17] ^ den[16];
        norm_sat = {2'b00, un} >= {1'b0, ud, 2'b00};
    end

    // One restoring division step and the signed, saturated quotient.
    always_comb begin
        div_t    = {r_rem, r_dsh[QW-1]};
        div_diff = div_t - {1'b0, r_ud};
        div_ge   = div_t >= {1'b0, r_ud};
        if (r_sat) begin
            norm_val = r_neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
        end else begin
            norm_val = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        end
    end

    // Rotator operands: normalized axes widened, and the per-step shifts.
    assign pre_x      = {{2{r_nx[NW-1]}}, r_nx};
    assign pre_y      = {{2{r_ny[NW-1]}}, r_ny};
    assign pre_direct = (r_nx == '0) || (r_ny == '0);
    assign sh_x       = r_x >>> r_step;
    assign sh_y       = r_y >>> r_step;

    // Whole degrees with the full-turn wrap.
    assign deg_raw  = r_z[ANG_FRAC+9:ANG_FRAC];
    assign deg_wrap = (deg_raw >= DEG_TURN) ? deg_raw - DEG_TURN : deg_raw;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take && i_in_data.func == FUNC_HEAD) begin
                    n_state = span_zero ? ST_DONE : ST_NORM_LOAD;
                end
            end
            ST_NORM_LOAD: n_state = norm_sat ? ST_NORM_END : ST_NORM_DIV;
            ST_NORM_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_NORM_END;
                end
            end
            ST_NORM_END: n_state = r_axis ? ST_ROT_PRE : ST_NORM_LOAD;
            ST_ROT_PRE:  n_state = pre_direct ? ST_WRAP : ST_ROT_STEP;
            ST_ROT_STEP: begin
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    assign n_out_valid = out_load || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Datapath next values.
    always_comb begin
        n_x_min = r_x_min;
        n_x_max = r_x_max;
        n_y_min = r_y_min;
        n_y_max = r_y_max;
        n_xv    = r_xv;
        n_yv    = r_yv;
        n_err   = r_err;
        n_axis  = r_axis;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_ud    = r_ud;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_nx    = r_nx;
        n_ny    = r_ny;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_step  = r_step;
        n_out   = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_xv   = in_xv;
                    n_yv   = in_yv;
                    n_axis = 1'b0;
                    n_err  = span_zero;
                    n_z    = '0;
                    if (i_in_data.func == FUNC_CAL) begin
                        if (in_xv < r_x_min) n_x_min = in_xv;
                        if (in_xv > r_x_max) n_x_max = in_xv;
                        if (in_yv < r_y_min) n_y_min = in_yv;
                        if (in_yv > r_y_max) n_y_max = in_yv;
                    end
                end
            end
            ST_NORM_LOAD: begin
                n_neg = norm_neg;
                n_sat = norm_sat;
                n_ud  = ud;
                n_rem = {1'b0, un[16:2]};
                n_dsh = {un[1:0], {FRAC_BITS{1'b0}}};
                n_q   = '0;
                n_cnt = DW'(FRAC_BITS + 1);
            end
            ST_NORM_DIV: begin
                n_rem = div_ge ? div_diff[15:0] : div_t[15:0];
                n_q   = {r_q[QW-2:0], div_ge};
                n_dsh = r_dsh << 1;
                n_cnt = r_cnt - DW'(1);
            end
            ST_NORM_END: begin
                if (r_axis) begin
                    n_ny = norm_val;
                end else begin
                    n_nx = norm_val;
                end
                n_axis = 1'b1;
            end
            ST_ROT_PRE: begin
                n_step = '0;
                n_x    = pre_x;
                n_y    = pre_y;
                n_z    = '0;
                if (r_nx == '0 && r_ny == '0) begin
                    n_z = '0;
                end else if (r_ny == '0) begin
                    n_z = r_nx[NW-1] ? Z_180 : '0;
                end else if (r_nx == '0) begin
                    n_z = r_ny[NW-1] ? -Z_90 : Z_90;
                end else if (r_nx[NW-1]) begin
                    // Left half plane: turn by a quarter so the rotator starts at x > 0.
                    if (!r_ny[NW-1]) begin
                        n_x = pre_y;
                        n_y = -pre_x;
                        n_z = Z_90;
                    end else begin
                        n_x = -pre_y;
                        n_y = pre_x;
                        n_z = -Z_90;
                    end
                end
            end
            ST_ROT_STEP: begin
                if (!r_y[CW-1]) begin
                    n_x = r_x + sh_y;
                    n_y = r_y - sh_x;
                    n_z = r_z + atan_deg(TBL_IW'(r_step));
                end else begin
                    n_x = r_x - sh_y;
                    n_y = r_y + sh_x;
                    n_z = r_z - atan_deg(TBL_IW'(r_step));
                end
                n_step = r_step + SW'(1);
            end
            ST_WRAP: begin
                if (r_z[ZW-1]) begin
                    n_z = r_z + Z_360;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out.heading_deg = deg_wrap[8:0];
                    n_out.range_error = r_err;
                end
            end
            default: ;
        endcase
    end

    // Control state and calibration limits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_x_min     <= 16'sh7FFF;
            r_x_max     <= 16'sh8000;
            r_y_min     <= 16'sh7FFF;
            r_y_max     <= 16'sh8000;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_x_min     <= n_x_min;
            r_x_max     <= n_x_max;
            r_y_min     <= n_y_min;
            r_y_max     <= n_y_max;
        end
    end

    // Working registers of the divider and rotator.
    always_ff @(posedge i_clk) begin
        r_xv   <= n_xv;
        r_yv   <= n_yv;
        r_err  <= n_err;
        r_axis <= n_axis;
        r_neg  <= n_neg;
        r_sat  <= n_sat;
        r_ud   <= n_ud;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_step <= n_step;
        r_out  <= n_out;
    end

    // A range error always reports heading zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |-> o_out_data.heading_deg == '0)
        else $error("range error with nonzero heading");

    // Headings stay within one turn.
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.heading_deg < 9'd360)
        else $error("heading out of range");

    // After any calibration item the limits are ordered.
    a_cal_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in_data.func == FUNC_CAL
        |=> (r_x_min <= r_x_max) && (r_y_min <= r_y_max))
        else $error("calibration limits out of order");

    // A heading item keeps the block busy in the next cycle.
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in_data.func == FUNC_HEAD |=> o_in_stall)
        else $error("heading item did not occupy the sequencer");

    // The rotation counter never passes the last step.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROT_STEP |-> r_step <= SW'(CORDIC_STEPS - 1))
        else $error("rotation step counter overran");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
    import chc_pkg::*;

    localparam int FRAC_Q         = FRAC_BITS_DEF;
    localparam int ROT_STEPS      = CORDIC_STEPS_DEF;
    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 70;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_ROWS         = 21;

    // Arctangent of 2^-i in degrees, sixteen fraction bits.
    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b1;

    compass_heading_calibrated dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always #2 i_clk = ~i_clk;

    // Running calibration limits as the block should hold them.
    logic signed [15:0] cal_x_min = 16'sd32767;
    logic signed [15:0] cal_x_max = -16'sd32768;
    logic signed [15:0] cal_y_min = 16'sd32767;
    logic signed [15:0] cal_y_max = -16'sd32768;

    t_out_item pending_headings[$];
    int        mismatches = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        idle_cycles = 0;

    // Normalized axis in Q3.16: (2v-min-max)/(max-min), truncated and saturated.
    function automatic longint norm_axis(input logic signed [15:0] v,
                                         input logic signed [15:0] lo,
                                         input logic signed [15:0] hi);
        longint          num;
        longint          den;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned cap;
        bit              neg;
        num = 2 * longint'(v) - longint'(lo) - longint'(hi);
        den = longint'(hi) - longint'(lo);
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = (un << FRAC_Q) / ud;
        cap = longint'(4) << FRAC_Q;
        if (!neg)
            cap = cap - 1;
        if (q > cap)
            q = cap;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Angle of (x, y) in Q10.16 degrees by vectoring rotations.
    function automatic longint vector_angle(input longint x, input longint y);
        longint z;
        longint t;
        longint nx;
        longint ny;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (y == 0)
            return (x > 0) ? 0 : (longint'(180) << ANG_FRAC);
        if (x == 0)
            return (y > 0) ? (longint'(90) << ANG_FRAC) : -(longint'(90) << ANG_FRAC);
        // Fold the left half plane onto the right one first.
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y;
                y = -t;
                z = longint'(90) << ANG_FRAC;
            end else begin
                x = -y;
                y = t;
                z = -(longint'(90) << ANG_FRAC);
            end
        end
        for (int i = 0; i < ROT_STEPS && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_Q16[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_Q16[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Applies one item to the calibration state; returns 1 with the heading
    // when the item is a heading request.
    function automatic bit compute_heading(input t_in_item it, output t_out_item res);
        logic signed [15:0] xv;
        logic signed [15:0] yv;
        longint             z;
        longint             deg;
        xv  = {it.x_high, it.x_low};
        yv  = {it.y_high, it.y_low};
        res = '0;
        if (it.func == FUNC_CAL) begin
            if (xv < cal_x_min) cal_x_min = xv;
            if (xv > cal_x_max) cal_x_max = xv;
            if (yv < cal_y_min) cal_y_min = yv;
            if (yv > cal_y_max) cal_y_max = yv;
            return 1'b0;
        end
        if (cal_x_max == cal_x_min || cal_y_max == cal_y_min) begin
            res.range_error = 1'b1;
            return 1'b1;
        end
        z = vector_angle(norm_axis(xv, cal_x_min, cal_x_max),
                         norm_axis(yv, cal_y_min, cal_y_max));
        if (z < 0)
            z = z + (longint'(360) << ANG_FRAC);
        deg = z >>> ANG_FRAC;
        while (deg >= 360)
            deg = deg - 360;
        res.heading_deg = deg[8:0];
        return 1'b1;
    endfunction

    // Offers one item, called at a falling edge; returns at the falling edge
    // after it was taken. A typed expectation replaces the predicted one.
    task automatic offer(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        if (compute_heading(it, res))
            pending_headings.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        if ($urandom_range(1))
            return 16'($urandom);
        return 16'($urandom_range(4000) - 2000);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_headings.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result heading=%0d error=%0b", $time,
                         out_data.heading_deg, out_data.range_error);
            end else begin
                want = pending_headings.pop_front();
                if (out_data.heading_deg !== want.heading_deg) begin
                    mismatches++;
                    $display("%0t: heading_deg expected %0d actual %0d", $time,
                             want.heading_deg, out_data.heading_deg);
                end
                if (out_data.range_error !== want.range_error) begin
                    mismatches++;
                    $display("%0t: range_error expected %0b actual %0b", $time,
                             want.range_error, out_data.range_error);
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    typedef struct packed {
        logic        func;
        logic [15:0] x;
        logic [15:0] y;
        logic        typed;
        logic [8:0]  deg;
        logic        err;
    } t_dir_row;

    // Directed rows: uncalibrated spans, zero spans, the four axes, the
    // origin, saturation of the normalized axes, and the widest calibration.
    localparam t_dir_row DIR_ROWS [N_ROWS] = '{
        '{FUNC_HEAD, 16'sd0,      16'sd0,      1'b0, 9'd0,   1'b0},
        '{FUNC_CAL,  16'sd0,      16'sd0,      1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd5,      16'sd5,      1'b1, 9'd0,   1'b1},
        '{FUNC_CAL,  16'sd100,    16'sd0,      1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd50,     -16'sd7,     1'b1, 9'd0,   1'b1},
        '{FUNC_CAL,  -16'sd100,   16'sd100,    1'b0, 9'd0,   1'b0},
        '{FUNC_CAL,  16'sd0,      -16'sd100,   1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd100,    16'sd0,      1'b1, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd0,      16'sd100,    1'b1, 9'd90,  1'b0},
        '{FUNC_HEAD, -16'sd100,   16'sd0,      1'b1, 9'd180, 1'b0},
        '{FUNC_HEAD, 16'sd0,      -16'sd100,   1'b1, 9'd270, 1'b0},
        '{FUNC_HEAD, 16'sd0,      16'sd0,      1'b1, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd50,     16'sd50,     1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, -16'sd70,    16'sd30,     1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, -16'sd1,     -16'sd1,     1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd32767,  -16'sd32768, 1'b0, 9'd0,   1'b0},
        '{FUNC_CAL,  -16'sd32768, -16'sd32768, 1'b0, 9'd0,   1'b0},
        '{FUNC_CAL,  16'sd32767,  16'sd32767,  1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd32767,  -16'sd32768, 1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, -16'sd32768, 16'sd32767,  1'b0, 9'd0,   1'b0},
        '{FUNC_HEAD, 16'sd1,      -16'sd2,     1'b0, 9'd0,   1'b0}
    };

    initial begin : stimulus
        t_in_item  it;
        t_out_item typed_res;
        logic [15:0] xs;
        logic [15:0] ys;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_gap_pct   = 37;
        recv_stall_pct = 65;

        // Directed part.
        for (int r = 0; r < N_ROWS; r++) begin
            it.func   = DIR_ROWS[r].func;
            it.x_low  = DIR_ROWS[r].x[7:0];
            it.x_high = DIR_ROWS[r].x[15:8];
            it.y_low  = DIR_ROWS[r].y[7:0];
            it.y_high = DIR_ROWS[r].y[15:8];
            typed_res.heading_deg = DIR_ROWS[r].deg;
            typed_res.range_error = DIR_ROWS[r].err;
            offer(it, DIR_ROWS[r].typed, typed_res);
        end

        // Random part in three idling phases; the long hold-off opens the last.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_gap_pct   = 65;
                recv_stall_pct = 37;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
                hold_req       = 1'b1;
            end
            xs = rand_axis();
            ys = rand_axis();
            it.func   = ($urandom_range(99) < 30) ? FUNC_CAL : FUNC_HEAD;
            it.x_low  = xs[7:0];
            it.x_high = xs[15:8];
            it.y_low  = ys[7:0];
            it.y_high = ys[15:8];
            offer(it, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_headings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/chc_pkg.sv
rtl/core/compass_heading_calibrated.sv
verif/tb_top.sv
